>>> hw/rtl/rtss_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, codes and widths of the record table block.
package rtss_pkg;
    localparam int NUM_W   = 16;
    localparam int QTY_W   = 16;
    localparam int PRICE_W = 24;
    localparam int REC_W   = NUM_W + QTY_W + PRICE_W;
    localparam logic [15:0] THRESH_RESET = 16'd100;

    typedef enum logic [2:0] {
        ACT_CLEAR   = 3'd0,
        ACT_APPEND  = 3'd1,
        ACT_LIST    = 3'd2,
        ACT_SORT_PR = 3'd3,
        ACT_SORT_NU = 3'd4,
        ACT_LOOKUP  = 3'd5,
        ACT_REORDER = 3'd6,
        ACT_NONE    = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ST_RECORD   = 3'd0,
        ST_DONE     = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KEY_PRICE = 2'd0,
        KEY_NUMBER = 2'd1,
        KEY_QTY_DESC = 2'd2
    } t_key;

    typedef enum logic [3:0] {
        S_IDLE, S_SORT_RD, S_SORT_WAIT, S_SORT_CMP, S_SORT_WR,
        S_SCAN_RD, S_SCAN_WAIT, S_SCAN_CHK, S_EMIT
    } t_state;

    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic [QTY_W-1:0]   quantity;
        logic [PRICE_W-1:0] price;
    } t_rec;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_cnt;
        logic append;
        logic latch_in;
        logic sort_init;   // i = 0, j = 0
        logic sort_rd;     // read entries i and j
        logic sort_swap;   // write swapped pair
        logic sort_adv;    // step j, then i
        logic scan_init;
        logic scan_rd;
        logic scan_adv;
        logic load_out;
        t_status out_st;
        logic out_rec;     // payload from scanned record
        logic out_num;     // payload number from searched number
        logic out_last;
        logic set_found;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic sort_done;
        logic out_of_order;
        logic scan_done;
        logic scan_hit;
        logic last_entry;  // scan index is on the final table entry
        logic found;
        t_action action;
    } t_sts;
endpackage

>>> hw/rtl/rtss_if.sv
`timescale 1ns / 1ps
// Interfaces: input and result channels of the record table block.
interface rtss_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] item_number;
    logic [15:0] quantity;
    logic [23:0] price_cents;
    modport source (output valid, action, item_number, quantity, price_cents, input ready);
    modport sink   (input valid, action, item_number, quantity, price_cents, output ready);
endinterface

interface rtss_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] out_number;
    logic [15:0] out_quantity;
    logic [23:0] out_price;
    logic        last;
    modport source (output valid, status, out_number, out_quantity, out_price, last,
                    input ready);
    modport sink   (input valid, status, out_number, out_quantity, out_price, last,
                    output ready);
endinterface

>>> hw/rtl/rtss_ram.sv
`timescale 1ns / 1ps
// Generic RAM: two ports, each read or write, registered read.
module rtss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we_a,
    input  logic [$clog2(DEPTH)-1:0] i_addr_a,
    input  logic [WIDTH-1:0]         i_wdata_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_we_b,
    input  logic [$clog2(DEPTH)-1:0] i_addr_b,
    input  logic [WIDTH-1:0]         i_wdata_b,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we_a) begin
            r_mem[i_addr_a] <= i_wdata_a;
        end
        if (i_we_b) begin
            r_mem[i_addr_b] <= i_wdata_b;
        end
        o_rdata_a <= r_mem[i_addr_a];
        o_rdata_b <= r_mem[i_addr_b];
    end
endmodule

>>> hw/rtl/rtss_datapath.sv
`timescale 1ns / 1ps
// Datapath: record memory, sort and scan indexes, compare, output register.
module rtss_datapath #(
    parameter int ENTRIES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtss_pkg::t_cmd      i_cmd,
    output rtss_pkg::t_sts      o_sts,
    input  logic [2:0]          i_action,
    input  logic [15:0]         i_item_number,
    input  logic [15:0]         i_quantity,
    input  logic [23:0]         i_price_cents,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    output logic [2:0]          o_status,
    output logic [15:0]         o_out_number,
    output logic [15:0]         o_out_quantity,
    output logic [23:0]         o_out_price,
    output logic                o_last
);
    import rtss_pkg::*;
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    logic [CW-1:0] r_count;
    logic [15:0]   r_thresh;
    t_action       r_action;
    t_rec          r_in;
    logic [CW-1:0] r_i, r_j;
    logic          r_found;
    t_key          w_key;
    t_rec          w_ra, w_rb, w_wa, w_wb;
    logic          w_we_a, w_we_b;
    logic [AW-1:0] w_addr_a, w_addr_b;
    logic          w_ooo;
    logic [CW-1:0] w_j_next;
    logic [CW-1:0] w_i_next;

    always_comb begin
        case (r_action)
            ACT_SORT_PR: w_key = KEY_PRICE;
            ACT_REORDER: w_key = KEY_QTY_DESC;
            default:     w_key = KEY_NUMBER;
        endcase
    end

    // Port a holds position i (or the append slot at the count), port b holds position j.
    always_comb begin
        w_we_a = 1'b0;
        w_we_b = 1'b0;
        w_addr_a = r_i[AW-1:0];
        w_addr_b = r_j[AW-1:0];
        w_wa = w_rb;
        w_wb = w_ra;
        if (i_cmd.append) begin
            // append happens in the accept cycle, so the record comes from the channel
            w_we_a = 1'b1;
            w_addr_a = r_count[AW-1:0];
            w_wa = '{number: i_item_number, quantity: i_quantity, price: i_price_cents};
        end else if (i_cmd.sort_swap) begin
            w_we_a = 1'b1;
            w_we_b = 1'b1;
        end
    end

    rtss_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
        .i_clk     (i_clk),
        .i_we_a    (w_we_a),
        .i_addr_a  (w_addr_a),
        .i_wdata_a (w_wa),
        .o_rdata_a (w_ra),
        .i_we_b    (w_we_b),
        .i_addr_b  (w_addr_b),
        .i_wdata_b (w_wb),
        .o_rdata_b (w_rb)
    );

    always_comb begin
        case (w_key)
            KEY_PRICE:  w_ooo = w_ra.price > w_rb.price;
            KEY_NUMBER: w_ooo = w_ra.number > w_rb.number;
            default:    w_ooo = w_ra.quantity < w_rb.quantity;
        endcase
    end

    assign w_j_next = r_j + 1'b1;
    assign w_i_next = r_i + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_thresh <= THRESH_RESET;
            r_found  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (i_cmd.clear_cnt) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.latch_in) begin
                r_found <= 1'b0;
            end else if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_action <= t_action'(i_action);
            r_in     <= '{number: i_item_number, quantity: i_quantity, price: i_price_cents};
        end
        if (i_cmd.sort_init || i_cmd.scan_init) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.sort_adv) begin
            if (w_j_next >= r_count) begin
                r_i <= r_i + 1'b1;
                r_j <= r_i + 1'b1;
            end else begin
                r_j <= w_j_next;
            end
        end else if (i_cmd.scan_adv) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.load_out) begin
            o_status <= i_cmd.out_st;
            o_last   <= i_cmd.out_last;
            if (i_cmd.out_rec) begin
                o_out_number   <= w_ra.number;
                o_out_quantity <= w_ra.quantity;
                o_out_price    <= w_ra.price;
            end else begin
                o_out_number   <= i_cmd.out_num ? r_in.number : '0;
                o_out_quantity <= '0;
                o_out_price    <= '0;
            end
        end
    end

    always_comb begin
        o_sts.full         = r_count == FULL_CNT;
        o_sts.empty        = r_count == '0;
        o_sts.sort_done    = r_i >= r_count;
        o_sts.out_of_order = w_ooo;
        o_sts.scan_done    = r_i >= r_count;
        o_sts.last_entry   = w_i_next == r_count;
        o_sts.found        = r_found;
        o_sts.action       = r_action;
        case (r_action)
            ACT_LOOKUP:  o_sts.scan_hit = w_ra.number == r_in.number;
            ACT_REORDER: o_sts.scan_hit = w_ra.quantity < r_thresh;
            default:     o_sts.scan_hit = 1'b1;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= FULL_CNT)
        else $error("entry count beyond table depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> !o_sts.full)
        else $error("append into a full table");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sort_swap |-> !i_cmd.append)
        else $error("swap and append together");
endmodule

>>> hw/rtl/rtss_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences actions, the exchange sort, scans and result hand-off.
module rtss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [2:0]     i_action,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  rtss_pkg::t_sts i_sts,
    output rtss_pkg::t_cmd o_cmd
);
    import rtss_pkg::*;
    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   r_more, n_more;   // a record was emitted, so the scan ends with no closing status item
    logic   w_take, w_free;

    assign w_take  = i_valid && o_ready;
    assign w_free  = !r_ovalid || i_ready;
    assign o_valid = r_ovalid;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_more   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_more   <= n_more;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    case (t_action'(i_action))
                        ACT_SORT_PR, ACT_SORT_NU, ACT_LOOKUP, ACT_REORDER:
                            n_state = S_SORT_RD;
                        ACT_LIST: n_state = S_SCAN_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SORT_RD:   n_state = i_sts.sort_done ? S_SCAN_RD : S_SORT_WAIT;
            S_SORT_WAIT: n_state = S_SORT_CMP;
            S_SORT_CMP:  n_state = i_sts.out_of_order ? S_SORT_WR : S_SORT_RD;
            S_SORT_WR:   n_state = S_SORT_RD;
            S_SCAN_RD: begin
                if (i_sts.action == ACT_SORT_PR || i_sts.action == ACT_SORT_NU) begin
                    n_state = w_free ? S_IDLE : S_EMIT;
                end else if (i_sts.scan_done) begin
                    n_state = w_free ? S_IDLE : S_EMIT;
                end else begin
                    n_state = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_sts.scan_hit) begin
                    n_state = w_free ? S_SCAN_RD : S_SCAN_CHK;
                    if (i_sts.action == ACT_LOOKUP && w_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_EMIT:  n_state = w_free ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.out_st = ST_DONE;
        n_ovalid = r_ovalid && !i_ready;
        n_more = r_more;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    o_cmd.latch_in = 1'b1;
                    o_cmd.sort_init = 1'b1;
                    n_more = 1'b0;
                    case (t_action'(i_action))
                        ACT_CLEAR: begin
                            o_cmd.clear_cnt = 1'b1;
                            o_cmd.load_out = 1'b1;
                            o_cmd.out_last = 1'b1;
                            n_ovalid = 1'b1;
                        end
                        ACT_APPEND: begin
                            o_cmd.append = !i_sts.full;
                            o_cmd.out_st = i_sts.full ? ST_FULL : ST_DONE;
                            o_cmd.load_out = 1'b1;
                            o_cmd.out_last = 1'b1;
                            n_ovalid = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_SORT_RD: begin
                if (i_sts.sort_done) begin
                    o_cmd.scan_init = 1'b1;
                end
            end
            S_SORT_CMP: begin
                if (!i_sts.out_of_order) begin
                    o_cmd.sort_adv = 1'b1;
                end
            end
            S_SORT_WR: begin
                o_cmd.sort_swap = 1'b1;
                o_cmd.sort_adv = 1'b1;
            end
            S_SCAN_RD, S_EMIT: begin
                // final item: done, empty or not found
                if ((r_state == S_EMIT || i_sts.scan_done ||
                     i_sts.action == ACT_SORT_PR || i_sts.action == ACT_SORT_NU)
                    && w_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_ovalid = 1'b1;
                    if (r_more) begin
                        o_cmd.load_out = 1'b0;
                        n_ovalid = r_ovalid && !i_ready;
                    end
                    if (i_sts.action == ACT_LOOKUP) begin
                        o_cmd.out_st = ST_NOTFOUND;
                        o_cmd.out_num = 1'b1;
                    end else if (i_sts.action == ACT_LIST ||
                                 i_sts.action == ACT_REORDER) begin
                        o_cmd.out_st = ST_EMPTY;
                    end
                end
                if (r_state == S_SCAN_RD && !i_sts.scan_done && i_sts.action != ACT_SORT_PR
                    && i_sts.action != ACT_SORT_NU) begin
                    o_cmd.scan_rd = 1'b1;
                end
            end
            S_SCAN_CHK: begin
                if (!i_sts.scan_hit) begin
                    o_cmd.scan_adv = 1'b1;
                end else if (w_free) begin
                    o_cmd.scan_adv = 1'b1;
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_rec = 1'b1;
                    o_cmd.out_st = ST_RECORD;
                    o_cmd.set_found = 1'b1;
                    n_ovalid = 1'b1;
                    n_more = 1'b1;
                    // reorder hits form a suffix of the descending table, so the
                    // final entry always closes a list or a reorder report
                    o_cmd.out_last = i_sts.action == ACT_LOOKUP || i_sts.last_entry;
                end
            end
            default: ;
        endcase
    end
endmodule

>>> hw/rtl/record_table_sort_search_top.sv
`timescale 1ns / 1ps
// Top level: record table with exchange sort, linear search and reorder report.
// Sorts run the exchange sort over the table through the two-port record RAM, with a
// read, a wait and a compare state per pair and a write state per swap; lookup and
// reorder sort first. Lookup, list and reorder scan the table with a read, a wait and
// a check state per record, and each result waits for the result channel. One item is
// in work at a time; the next is taken once the last result has been delivered.
module record_table_sort_search_top #(
    parameter int ENTRIES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtss_in_if.sink    i_in,
    rtss_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import rtss_pkg::*;
    t_cmd w_cmd;
    t_sts w_sts;

    rtss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_action(i_in.action),
        .o_ready (i_in.ready),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    rtss_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_action       (i_in.action),
        .i_item_number  (i_in.item_number),
        .i_quantity     (i_in.quantity),
        .i_price_cents  (i_in.price_cents),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_status       (o_out.status),
        .o_out_number   (o_out.out_number),
        .o_out_quantity (o_out.out_quantity),
        .o_out_price    (o_out.out_price),
        .o_last         (o_out.last)
    );
endmodule
